// ----- hw/rtl/rgb2yuv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgb2yuv_pkg - shared types and constants
// Frame geometry limits, register map, field widths and the bundles passed
// between the geometry tracker and the top level.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int COEF_FRAC_DEF  = 16;

	localparam int PIX_W        = 8;
	localparam int SIZE_W       = 13;
	localparam int LUMA_IDX_W   = 24;
	localparam int CHROMA_IDX_W = 22;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 72;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

	// register index = paddr[2]
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	// position info of one pixel, produced at input transfer
	typedef struct packed {
		logic [LUMA_IDX_W-1:0]   luma_index;
		logic [CHROMA_IDX_W-1:0] chroma_index;
		logic                    chroma_valid;
		logic                    frame_end;
	} pos_t;

endpackage

// ----- hw/rtl/rgb_to_yuv420_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter - RGB to YCbCr 4:2:0 pixel stream converter
// Path: an input pixel is held in stage 1, then in the output register.
// Throughput: one pixel per cycle unless the output stalls; the output register
// and the input stage decouple, so a stalled result still lets one new pixel in.
// Reset: arst_n clears valid flags and raster counters; frame size registers
// return to 640 x 480.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter #(
	parameter int MAX_WIDTH      = rgb2yuv_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT     = rgb2yuv_pkg::MAX_HEIGHT_DEF,
	parameter int COEF_FRAC_BITS = rgb2yuv_pkg::COEF_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rgb2yuv_pkg::APB_AW-1:0]      paddr,
	input  logic [rgb2yuv_pkg::APB_DW-1:0]      pwdata,
	output logic [rgb2yuv_pkg::APB_DW-1:0]      prdata,
	output logic                                pready,
	// pixel input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [rgb2yuv_pkg::IN_DATA_W-1:0]   s_tdata,
	// result output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// luma [7:0], luma_index [31:8], blue_difference [39:32],
	// red_difference [47:40], chroma_index [69:48], zero [71:70]
	output logic [rgb2yuv_pkg::OUT_DATA_W-1:0]  m_tdata,
	// chroma_valid [0]
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import rgb2yuv_pkg::*;

	logic accept, load_s2;

	// stage 1: captured pixel with its plane positions
	logic valid_s1;
	pix_t pix_s1;
	pos_t pos_s1;
	pos_t pos_now;

	// stage 2: output register
	logic                    valid_s2;
	logic [PIX_W-1:0]        luma_s2, cb_s2, cr_s2;
	logic [LUMA_IDX_W-1:0]   lidx_s2;
	logic [CHROMA_IDX_W-1:0] cidx_s2;
	logic                    cvalid_s2, fend_s2;

	logic [PIX_W-1:0] y_w, cb_w, cr_w;

	assign pready = 1'b1;

	// advance the output register when it is empty or being drained;
	// take a new pixel whenever stage 1 is empty or moving on
	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || load_s2;
	assign accept   = s_tvalid && s_tready;

	rgb2yuv_geom #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.advance (accept),
		.pos     (pos_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: capture on transfer, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_t'(s_tdata);
			pos_s1 <= pos_now;
		end
	end

	rgb2yuv_csc #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_csc (
		.pix             (pix_s1),
		.luma            (y_w),
		.blue_difference (cb_w),
		.red_difference  (cr_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// chroma samples read as zero off the even/even grid
	always_ff @(posedge clk) begin
		if (load_s2) begin
			luma_s2   <= y_w;
			lidx_s2   <= pos_s1.luma_index;
			cvalid_s2 <= pos_s1.chroma_valid;
			cb_s2     <= pos_s1.chroma_valid ? cb_w : '0;
			cr_s2     <= pos_s1.chroma_valid ? cr_w : '0;
			cidx_s2   <= pos_s1.chroma_index;
			fend_s2   <= pos_s1.frame_end;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, cidx_s2, cr_s2, cb_s2, lidx_s2, luma_s2};
	assign m_tuser  = cvalid_s2;
	assign m_tlast  = fend_s2;

	// chroma payload must be zero whenever chroma is not flagged
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[69:32] == '0))
		else $error("chroma fields nonzero without chroma_valid");

	// input stalls only when both stages are full and the output is blocked
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled with room in the pipeline");

	// a held stage 1 pixel is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_s2) |=> valid_s1)
		else $error("stage 1 pixel lost");

endmodule

// ----- hw/rtl/rgb2yuv_csc.sv -----
// ----------------------------------------------------------------------------
// rgb2yuv_csc - color space conversion
// Fixed-point BT.601 RGB to Y/Cb/Cr, truncated and clamped to 0..255.
// ----------------------------------------------------------------------------
module rgb2yuv_csc #(
	parameter int COEF_FRAC_BITS = rgb2yuv_pkg::COEF_FRAC_DEF
) (
	input  rgb2yuv_pkg::pix_t                 pix,
	output logic [rgb2yuv_pkg::PIX_W-1:0]     luma,
	output logic [rgb2yuv_pkg::PIX_W-1:0]     blue_difference,
	output logic [rgb2yuv_pkg::PIX_W-1:0]     red_difference
);
	import rgb2yuv_pkg::*;

	localparam int SW = COEF_FRAC_BITS + 10;

	localparam longint K299 = ((longint'(299) << COEF_FRAC_BITS) + 64'sd500) / 1000;
	localparam longint K587 = ((longint'(587) << COEF_FRAC_BITS) + 64'sd500) / 1000;
	localparam longint K114 = ((longint'(114) << COEF_FRAC_BITS) + 64'sd500) / 1000;
	localparam longint K169 = ((longint'(169) << COEF_FRAC_BITS) + 64'sd500) / 1000;
	localparam longint K331 = ((longint'(331) << COEF_FRAC_BITS) + 64'sd500) / 1000;
	localparam longint K500 = ((longint'(500) << COEF_FRAC_BITS) + 64'sd500) / 1000;
	localparam longint K419 = ((longint'(419) << COEF_FRAC_BITS) + 64'sd500) / 1000;
	localparam longint K081 = ((longint'(81) << COEF_FRAC_BITS) + 64'sd500) / 1000;

	localparam logic [SW-1:0] C_YR  = SW'(K299);
	localparam logic [SW-1:0] C_YG  = SW'(K587);
	localparam logic [SW-1:0] C_YB  = SW'(K114);
	localparam logic [SW-1:0] C_UR  = SW'(K169);
	localparam logic [SW-1:0] C_UG  = SW'(K331);
	localparam logic [SW-1:0] C_HALF = SW'(K500);
	localparam logic [SW-1:0] C_VG  = SW'(K419);
	localparam logic [SW-1:0] C_VB  = SW'(K081);
	localparam logic [SW-1:0] OFFSET = SW'(128) << COEF_FRAC_BITS;

	// drop fraction, clamp to 0..255
	function automatic logic [PIX_W-1:0] to_byte(input logic [SW-1:0] pos,
		input logic [SW-1:0] neg);
		logic [SW-1:0] q;
		q = (pos - neg) >> COEF_FRAC_BITS;
		if (neg > pos)
			return '0;
		else if (q > SW'(255))
			return 8'hFF;
		else
			return q[PIX_W-1:0];
	endfunction

	logic [SW-1:0] r_w, g_w, b_w;
	logic [SW-1:0] y_pos, u_pos, u_neg, v_pos, v_neg;

	assign r_w = SW'(pix.red);
	assign g_w = SW'(pix.green);
	assign b_w = SW'(pix.blue);

	assign y_pos = C_YR * r_w + C_YG * g_w + C_YB * b_w;
	assign u_pos = C_HALF * b_w + OFFSET;
	assign u_neg = C_UR * r_w + C_UG * g_w;
	assign v_pos = C_HALF * r_w + OFFSET;
	assign v_neg = C_VG * g_w + C_VB * b_w;

	assign luma            = to_byte(y_pos, '0);
	assign blue_difference = to_byte(u_pos, u_neg);
	assign red_difference  = to_byte(v_pos, v_neg);

endmodule

// ----- hw/rtl/rgb2yuv_geom.sv -----
// ----------------------------------------------------------------------------
// rgb2yuv_geom - frame geometry tracker
// Holds the frame size registers and the raster counters, and produces the
// luma and chroma plane positions of each pixel as it is transferred in.
// ----------------------------------------------------------------------------
module rgb2yuv_geom #(
	parameter int MAX_WIDTH  = rgb2yuv_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgb2yuv_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rgb2yuv_pkg::APB_AW-1:0]   paddr,
	input  logic [rgb2yuv_pkg::APB_DW-1:0]   pwdata,
	output logic [rgb2yuv_pkg::APB_DW-1:0]   prdata,
	input  logic                             advance,
	output rgb2yuv_pkg::pos_t                pos
);
	import rgb2yuv_pkg::*;

	localparam int CW_W = $clog2(MAX_WIDTH);
	localparam int RW_W = $clog2(MAX_HEIGHT);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int CMPW = SIZE_W + 2;

	logic [SIZE_W-1:0]       width_q, height_q;
	logic [CW_W-1:0]         col_q;
	logic [RW_W-1:0]         row_q;
	logic [LUMA_IDX_W-1:0]   luma_q;
	logic [CHROMA_IDX_W-1:0] cbase_q;

	logic          wr_en;
	reg_idx_t      idx;
	logic [WW-1:0] w_eff, cstride;
	logic [HW-1:0] h_eff;
	logic          last_col, last_row, cvalid;

	assign wr_en = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_FRAME_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = APB_DW'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(height_q);
			default:          prdata = '0;
		endcase
	end

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		if (width_q == '0)
			w_eff = WW'(1);
		else if (CMPW'(width_q) > CMPW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);
		if (height_q == '0)
			h_eff = HW'(1);
		else if (CMPW'(height_q) > CMPW'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(height_q);
	end

	assign cstride  = WW'((CMPW'(w_eff) + CMPW'(1)) >> 1);
	assign last_col = (CMPW'(col_q) + CMPW'(1)) >= CMPW'(w_eff);
	assign last_row = (CMPW'(row_q) + CMPW'(1)) >= CMPW'(h_eff);
	assign cvalid   = !col_q[0] && !row_q[0];

	always_comb begin
		pos.luma_index   = luma_q;
		pos.chroma_valid = cvalid;
		pos.chroma_index = cvalid ? cbase_q + CHROMA_IDX_W'(col_q >> 1) : '0;
		pos.frame_end    = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			luma_q  <= '0;
			cbase_q <= '0;
		end else if (wr_en && (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT)) begin
			col_q   <= '0;
			row_q   <= '0;
			luma_q  <= '0;
			cbase_q <= '0;
		end else if (advance) begin
			if (last_col && last_row) begin
				col_q   <= '0;
				row_q   <= '0;
				luma_q  <= '0;
				cbase_q <= '0;
			end else if (last_col) begin
				col_q  <= '0;
				row_q  <= RW_W'(row_q + 1'b1);
				luma_q <= luma_q + 1'b1;
				if (row_q[0])
					cbase_q <= cbase_q + CHROMA_IDX_W'(cstride);
			end else begin
				col_q  <= CW_W'(col_q + 1'b1);
				luma_q <= luma_q + 1'b1;
			end
		end
	end

endmodule

// ----- bench/rgb_to_yuv420_converter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_test - self-checking bench for the 4:2:0 converter
// Streams RGB pixels through the converter under several frame geometries.
// The geometry registers are written over the APB-style port. A local
// color-space and raster model predicts every output sample, and the results
// are compared field by field as they come out. Both stream sides idle at
// random, and one long output stall forces the input to back up.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_test;
	import rgb2yuv_pkg::*;

	localparam int FRAC = COEF_FRAC_DEF;

	// Coefficients as unsigned fixed point, rounded to nearest; signs live in the sums.
	localparam longint unsigned Y_R  = ((64'd299 << FRAC) + 500) / 1000;
	localparam longint unsigned Y_G  = ((64'd587 << FRAC) + 500) / 1000;
	localparam longint unsigned Y_B  = ((64'd114 << FRAC) + 500) / 1000;
	localparam longint unsigned CB_R = ((64'd169 << FRAC) + 500) / 1000;
	localparam longint unsigned CB_G = ((64'd331 << FRAC) + 500) / 1000;
	localparam longint unsigned HALF = ((64'd500 << FRAC) + 500) / 1000;
	localparam longint unsigned CR_G = ((64'd419 << FRAC) + 500) / 1000;
	localparam longint unsigned CR_B = ((64'd81 << FRAC) + 500) / 1000;
	localparam longint unsigned OFFSET_128 = 64'd128 << FRAC;

	// One expected output sample.
	typedef struct {
		logic [PIX_W-1:0]        luma;
		logic [LUMA_IDX_W-1:0]   luma_index;
		logic                    chroma_valid;
		logic [PIX_W-1:0]        blue_difference;
		logic [PIX_W-1:0]        red_difference;
		logic [CHROMA_IDX_W-1:0] chroma_index;
		logic                    frame_end;
	} yuv_sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_AW-1:0]     paddr = '0;
	logic [APB_DW-1:0]     pwdata = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	rgb_to_yuv420_converter uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Pixels waiting to be sent and samples waiting to come out.
	pix_t        pending_pixels[$];
	yuv_sample_t expected_samples[$];

	// Local copy of the geometry registers and the raster position.
	logic [SIZE_W-1:0] width_cfg = WIDTH_RST;
	logic [SIZE_W-1:0] height_cfg = HEIGHT_RST;
	longint unsigned   col_pos = 0;
	longint unsigned   row_pos = 0;

	int  mismatches = 0;
	int  results_seen = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	bit  pressure_done = 1'b0;
	bit  calm_tail = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Register value as the converter uses it: zero acts as one, clamp to the maximum.
	function automatic longint unsigned active_size(logic [SIZE_W-1:0] v, int maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	// Drop the fraction of (pos - neg) and clamp to a byte; a negative sum gives zero.
	function automatic logic [PIX_W-1:0] clamp_byte(longint unsigned pos, longint unsigned neg);
		longint unsigned q;
		if (neg > pos)
			return '0;
		q = (pos - neg) >> FRAC;
		return (q > 255) ? 8'd255 : q[PIX_W-1:0];
	endfunction

	// Convert one pixel at the current raster position, then advance the position.
	function automatic yuv_sample_t convert_pixel(pix_t px);
		yuv_sample_t     s;
		longint unsigned r, g, b, w, h, idx;
		logic            last_col, last_row;
		r = px.red;
		g = px.green;
		b = px.blue;
		w = active_size(width_cfg, MAX_WIDTH_DEF);
		h = active_size(height_cfg, MAX_HEIGHT_DEF);
		s.luma = clamp_byte(Y_R * r + Y_G * g + Y_B * b, 0);
		idx = row_pos * w + col_pos;
		s.luma_index = idx[LUMA_IDX_W-1:0];
		s.chroma_valid = !col_pos[0] && !row_pos[0];
		if (s.chroma_valid) begin
			s.blue_difference = clamp_byte(HALF * b + OFFSET_128, CB_R * r + CB_G * g);
			s.red_difference = clamp_byte(HALF * r + OFFSET_128, CR_G * g + CR_B * b);
			// chroma stride is half the width rounded up, so odd widths never collide
			idx = (row_pos >> 1) * ((w + 1) >> 1) + (col_pos >> 1);
			s.chroma_index = idx[CHROMA_IDX_W-1:0];
		end else begin
			s.blue_difference = '0;
			s.red_difference = '0;
			s.chroma_index = '0;
		end
		last_col = (col_pos + 1 >= w);
		last_row = (row_pos + 1 >= h);
		s.frame_end = last_col && last_row;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return s;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Pixel driver: hold the offered pixel until the transfer, then load the next
	// one from the pending queue or insert a random idle burst.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			// predict at the transfer so the model sees pixels in stream order
			if (s_tvalid && s_tready)
				expected_samples.push_back(convert_pixel(pix_t'(s_tdata)));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0 && !calm_tail) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 11) - 1;
					s_tvalid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					s_tdata <= pending_pixels.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare every transfer with the oldest prediction and
	// drive the ready side with random stalls plus one long hold-off.
	always @(posedge clk) begin
		yuv_sample_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					check_field("luma", want.luma, m_tdata[7:0]);
					check_field("luma_index", want.luma_index, m_tdata[31:8]);
					check_field("blue_difference", want.blue_difference, m_tdata[39:32]);
					check_field("red_difference", want.red_difference, m_tdata[47:40]);
					check_field("chroma_index", want.chroma_index, m_tdata[69:48]);
					check_field("pad bits", 0, m_tdata[71:70]);
					check_field("chroma_valid", want.chroma_valid, m_tuser);
					check_field("frame_end", want.frame_end, m_tlast);
				end
			end
			// one long stall so the input side fills up and backs off
			if (!pressure_done && results_seen >= 60) begin
				recv_gap = 80;
				pressure_done = 1'b1;
			end
			if (recv_gap > 0 && !calm_tail) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 11) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Wait until nothing is queued, offered or outstanding, then let the pipeline empty.
	task automatic settle();
		@(negedge clk);
		while (pending_pixels.size() != 0 || s_tvalid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: setup phase, then access phase until pready. A geometry
	// write restarts the frame, so clear the local raster position as well.
	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_cfg = value[SIZE_W-1:0];
		else
			height_cfg = value[SIZE_W-1:0];
		col_pos = 0;
		row_pos = 0;
	endtask

	// Favor the extremes so saturation and all-ones pixels show up often.
	function automatic logic [PIX_W-1:0] random_level();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_random(int count);
		pix_t px;
		repeat (count) begin
			px.red = random_level();
			px.green = random_level();
			px.blue = random_level();
			pending_pixels.push_back(px);
		end
	endtask

	// Random geometry writes keep junk in the upper bits to exercise the 13-bit mask.
	function automatic logic [APB_DW-1:0] with_junk(int unsigned size);
		return {APB_DW'($urandom) & ~APB_DW'(13'h1FFF)} | APB_DW'(size);
	endfunction

	// Pixel extremes for the directed part: black, white, primaries, secondaries, gray.
	pix_t corner_pixels[9] = '{
		'{blue: 8'd0,   green: 8'd0,   red: 8'd0},
		'{blue: 8'd255, green: 8'd255, red: 8'd255},
		'{blue: 8'd0,   green: 8'd0,   red: 8'd255},
		'{blue: 8'd0,   green: 8'd255, red: 8'd0},
		'{blue: 8'd255, green: 8'd0,   red: 8'd0},
		'{blue: 8'd255, green: 8'd255, red: 8'd0},
		'{blue: 8'd0,   green: 8'd255, red: 8'd255},
		'{blue: 8'd255, green: 8'd0,   red: 8'd255},
		'{blue: 8'd128, green: 8'd128, red: 8'd128}
	};

	// Random phases: geometry per phase and pixel count. Zero marks a random size.
	int unsigned phase_width[11]  = '{16, 1, 5, 4096, 7, 1, 2, 8191, 0, 0, 6};
	int unsigned phase_height[11] = '{9, 1, 3, 4097, 1, 7, 2, 3, 0, 0, 5};
	int unsigned phase_count[11]  = '{160, 30, 80, 50, 50, 50, 40, 40, 50, 50, 60};

	initial begin
		int unsigned w, h;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry 640 x 480: first pixels of row zero
		for (int i = 0; i < 6; i++)
			pending_pixels.push_back(corner_pixels[i]);
		settle();

		// odd 3 x 3 frame, full frame to reach the end marker; upper bits masked off
		write_reg(REG_FRAME_WIDTH, 32'hFFFF_E003);
		write_reg(REG_FRAME_HEIGHT, 32'd3);
		for (int i = 0; i < 9; i++)
			pending_pixels.push_back(corner_pixels[i]);
		settle();

		// zero size acts as 1 x 1: every pixel ends a frame
		write_reg(REG_FRAME_WIDTH, 32'd0);
		write_reg(REG_FRAME_HEIGHT, 32'd0);
		for (int i = 5; i < 9; i++)
			pending_pixels.push_back(corner_pixels[i]);
		settle();

		// oversize width clamps to the maximum, single-row frame
		write_reg(REG_FRAME_WIDTH, 32'd8191);
		write_reg(REG_FRAME_HEIGHT, 32'd1);
		for (int i = 1; i < 4; i++)
			pending_pixels.push_back(corner_pixels[i]);
		settle();

		for (int p = 0; p < 11; p++) begin
			w = (phase_width[p] == 0) ? $urandom_range(1, 24) : phase_width[p];
			h = (phase_height[p] == 0) ? $urandom_range(1, 12) : phase_height[p];
			write_reg(REG_FRAME_WIDTH, with_junk(w));
			write_reg(REG_FRAME_HEIGHT, with_junk(h));
			// last phase runs with both sides always ready
			if (p == 10)
				calm_tail = 1'b1;
			queue_random(phase_count[p]);
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard stop in case the stream hangs.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/rgb2yuv_pkg.sv
hw/rtl/rgb2yuv_csc.sv
hw/rtl/rgb2yuv_geom.sv
hw/rtl/rgb_to_yuv420_converter.sv
bench/rgb_to_yuv420_converter_test.sv
